// File: src/msfi_pkg.sv
`timescale 1ns / 1ps
// msfi_pkg: widths, codes, queue entry type and helpers for the frame indexer
// depends on nothing; imported or referenced by every other file of the block

package msfi_pkg;

    localparam int STREAM_W     = 7;
    localparam int SEQ_W        = 8;
    localparam int SEG_LEN_W    = 16;
    localparam int PKT_W        = 32;
    localparam int FLAGS_W      = 8;
    localparam int BYTES_W      = 32;
    localparam int GAP_W        = 8;

    localparam int CNT_W        = 3;
    localparam int AUDIO_MAP_W  = 28;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 28;

    // track slots shown on the output, and how many of them the design keeps
    localparam int TRACK_SLOTS  = 4;
    localparam int TRACK_W      = $clog2(TRACK_SLOTS);
    localparam int AUDIO_TRACKS = 4;

    localparam logic [FLAGS_W-1:0] KEY_FLAG = 8'h10;

    // decoupling queue, depth is a power of two so pointers wrap naturally
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VIDEO_STREAM  = 2'd0,
        CFG_TRACK_COUNT   = 2'd1,
        CFG_AUDIO_STREAMS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [STREAM_W-1:0]    video_stream;
        logic [CNT_W-1:0]       track_count;
        logic [AUDIO_MAP_W-1:0] audio_streams;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_IGNORE = 2'd0,
        KIND_FLUSH  = 2'd1,
        KIND_VIDEO  = 2'd2,
        KIND_AUDIO  = 2'd3
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t              kind;
        logic [TRACK_W-1:0]     track;
        logic [SEQ_W-1:0]       seq;
        logic [SEG_LEN_W-1:0]   len;
        logic [PKT_W-1:0]       pkt;
        logic [FLAGS_W-1:0]     flags;
    } seg_op_t;

    // track count clamped to the tracks the design keeps
    function automatic logic [CNT_W-1:0] active_tracks(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] n;
        n = (count > CNT_W'(AUDIO_TRACKS)) ? CNT_W'(AUDIO_TRACKS) : count;
        return n;
    endfunction

endpackage

// File: src/msfi_seg_if.sv
`timescale 1ns / 1ps
// msfi_seg_if: segment input channel, valid/ready plus segment fields
// depends on msfi_pkg for field widths

interface msfi_seg_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [msfi_pkg::STREAM_W-1:0]  stream_number;
    logic [msfi_pkg::SEQ_W-1:0]     segment_sequence;
    logic [msfi_pkg::SEG_LEN_W-1:0] segment_length;
    logic [msfi_pkg::PKT_W-1:0]     packet_number;
    logic [msfi_pkg::FLAGS_W-1:0]   segment_flags;

    modport source (
        output valid, opcode, stream_number, segment_sequence, segment_length,
               packet_number, segment_flags,
        input  ready
    );

    modport sink (
        input  valid, opcode, stream_number, segment_sequence, segment_length,
               packet_number, segment_flags,
        output ready
    );
endinterface

// File: src/msfi_frame_if.sv
`timescale 1ns / 1ps
// msfi_frame_if: frame index output channel, valid/ready plus frame fields
// depends on msfi_pkg for field widths

interface msfi_frame_if;
    logic                         valid;
    logic                         ready;
    logic [msfi_pkg::GAP_W-1:0]   gap_frames;
    logic [msfi_pkg::BYTES_W-1:0] frame_length;
    logic [msfi_pkg::SEQ_W-1:0]   frame_sequence;
    logic [msfi_pkg::PKT_W-1:0]   frame_packet;
    logic [msfi_pkg::FLAGS_W-1:0] frame_flags;
    logic [msfi_pkg::BYTES_W-1:0] audio_bytes_track0;
    logic [msfi_pkg::BYTES_W-1:0] audio_bytes_track1;
    logic [msfi_pkg::BYTES_W-1:0] audio_bytes_track2;
    logic [msfi_pkg::BYTES_W-1:0] audio_bytes_track3;

    modport source (
        output valid, gap_frames, frame_length, frame_sequence, frame_packet,
               frame_flags, audio_bytes_track0, audio_bytes_track1,
               audio_bytes_track2, audio_bytes_track3,
        input  ready
    );

    modport sink (
        input  valid, gap_frames, frame_length, frame_sequence, frame_packet,
               frame_flags, audio_bytes_track0, audio_bytes_track1,
               audio_bytes_track2, audio_bytes_track3,
        output ready
    );
endinterface

// File: src/msfi_front.sv
`timescale 1ns / 1ps
// msfi_front: classifies an incoming segment into flush, video, audio track or ignore
// depends on msfi_pkg and msfi_seg_if

module msfi_front (
    msfi_seg_if.sink         seg,
    input  msfi_pkg::cfg_t   cfg,
    input  logic             queue_ready,
    output logic             op_valid,
    output msfi_pkg::seg_op_t op
);
    import msfi_pkg::*;

    logic [CNT_W-1:0]   n_tracks;
    logic               audio_hit;
    logic [TRACK_W-1:0] audio_track;

    assign n_tracks = active_tracks(cfg.track_count);

    // scan from the top so the lowest matching track wins
    always_comb
    begin
        audio_hit   = 1'b0;
        audio_track = '0;
        for (int t = AUDIO_TRACKS - 1; t >= 0; t--)
        begin
            if ((CNT_W'(t) < n_tracks) &&
                (cfg.audio_streams[STREAM_W*t +: STREAM_W] == seg.stream_number))
            begin
                audio_hit   = 1'b1;
                audio_track = TRACK_W'(t);
            end
        end
    end

    always_comb
    begin
        op.track = audio_track;
        op.seq   = seg.segment_sequence;
        op.len   = seg.segment_length;
        op.pkt   = seg.packet_number;
        op.flags = seg.segment_flags;
        if (seg.opcode)
            op.kind = KIND_FLUSH;
        else if (seg.stream_number == cfg.video_stream)
            op.kind = KIND_VIDEO;
        else if (audio_hit)
            op.kind = KIND_AUDIO;
        else
            op.kind = KIND_IGNORE;
    end

    assign seg.ready = queue_ready;
    assign op_valid  = seg.valid;

endmodule

// File: src/msfi_queue.sv
`timescale 1ns / 1ps
// msfi_queue: short register fifo between the classifier and the frame builder
// depends on msfi_pkg

module msfi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  msfi_pkg::seg_op_t push_op,
    output logic              pop_valid,
    input  logic              pop_ready,
    output msfi_pkg::seg_op_t pop_op
);
    import msfi_pkg::*;

    seg_op_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// File: src/msfi_back.sv
`timescale 1ns / 1ps
// msfi_back: open frame state, audio totals and the registered frame output
// depends on msfi_pkg and msfi_frame_if

module msfi_back (
    input  logic              clk,
    input  logic              rst_n,
    input  msfi_pkg::cfg_t    cfg,
    input  logic              op_valid,
    output logic              op_ready,
    input  msfi_pkg::seg_op_t op,
    msfi_frame_if.source      frame
);
    import msfi_pkg::*;

    logic                 open_reg;
    logic [SEQ_W-1:0]     open_seq_reg;
    logic [BYTES_W-1:0]   open_len_reg;
    logic [PKT_W-1:0]     open_pkt_reg;
    logic [FLAGS_W-1:0]   open_flags_reg;
    logic [BYTES_W-1:0]   totals_reg   [TRACK_SLOTS];
    logic [BYTES_W-1:0]   snapshot_reg [TRACK_SLOTS];

    logic                 out_valid_reg;
    logic [GAP_W-1:0]     out_gap_reg;
    logic [BYTES_W-1:0]   out_len_reg;
    logic [SEQ_W-1:0]     out_seq_reg;
    logic [PKT_W-1:0]     out_pkt_reg;
    logic [FLAGS_W-1:0]   out_flags_reg;
    logic [BYTES_W-1:0]   out_audio_reg [TRACK_SLOTS];

    logic                 take;
    logic                 emit;
    logic [GAP_W-1:0]     emit_gap;
    logic [BYTES_W-1:0]   len_ext;
    logic [CNT_W-1:0]     n_tracks;

    assign op_ready = !out_valid_reg || frame.ready;
    assign take     = op_valid && op_ready;
    assign len_ext  = BYTES_W'(op.len);
    assign n_tracks = active_tracks(cfg.track_count);

    // a frame closes on flush or on a video segment with a new sequence
    always_comb
    begin
        emit     = 1'b0;
        emit_gap = '0;
        unique case (op.kind)
            KIND_FLUSH:
                emit = open_reg;
            KIND_VIDEO:
            begin
                emit     = open_reg && (op.seq != open_seq_reg);
                emit_gap = op.seq - open_seq_reg - SEQ_W'(1);
            end
            default:
                emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            open_seq_reg   <= '0;
            open_len_reg   <= '0;
            open_pkt_reg   <= '0;
            open_flags_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int t = 0; t < TRACK_SLOTS; t++)
            begin
                totals_reg[t]   <= '0;
                snapshot_reg[t] <= '0;
            end
        end
        else
        begin
            // a new frame entry wins over the drain of the old one
            if (take && emit)
                out_valid_reg <= 1'b1;
            else if (frame.valid && frame.ready)
                out_valid_reg <= 1'b0;
            if (take)
            begin
                unique case (op.kind)
                    KIND_FLUSH:
                        open_reg <= 1'b0;
                    KIND_VIDEO:
                    begin
                        if (!open_reg)
                        begin
                            open_reg       <= 1'b1;
                            open_seq_reg   <= op.seq;
                            open_len_reg   <= len_ext;
                            open_pkt_reg   <= '0;
                            open_flags_reg <= KEY_FLAG;
                            for (int t = 0; t < TRACK_SLOTS; t++)
                                snapshot_reg[t] <= '0;
                        end
                        else if (op.seq == open_seq_reg)
                            open_len_reg <= open_len_reg + len_ext;
                        else
                        begin
                            open_seq_reg   <= op.seq;
                            open_len_reg   <= len_ext;
                            open_pkt_reg   <= op.pkt;
                            open_flags_reg <= op.flags;
                            for (int t = 0; t < TRACK_SLOTS; t++)
                                snapshot_reg[t] <= (CNT_W'(t) < n_tracks) ?
                                                   totals_reg[t] : '0;
                        end
                    end
                    KIND_AUDIO:
                        totals_reg[op.track] <= totals_reg[op.track] + len_ext;
                    default:
                        open_reg <= open_reg;
                endcase
            end
        end
    end

    // payload of the output register, loaded from the closing frame
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_gap_reg   <= emit_gap;
            out_len_reg   <= open_len_reg;
            out_seq_reg   <= open_seq_reg;
            out_pkt_reg   <= open_pkt_reg;
            out_flags_reg <= open_flags_reg;
            for (int t = 0; t < TRACK_SLOTS; t++)
                out_audio_reg[t] <= snapshot_reg[t];
        end
    end

    assign frame.valid              = out_valid_reg;
    assign frame.gap_frames         = out_gap_reg;
    assign frame.frame_length       = out_len_reg;
    assign frame.frame_sequence     = out_seq_reg;
    assign frame.frame_packet       = out_pkt_reg;
    assign frame.frame_flags        = out_flags_reg;
    assign frame.audio_bytes_track0 = out_audio_reg[0];
    assign frame.audio_bytes_track1 = out_audio_reg[1];
    assign frame.audio_bytes_track2 = out_audio_reg[2];
    assign frame.audio_bytes_track3 = out_audio_reg[3];

endmodule

// File: src/media_segment_frame_indexer.sv
`timescale 1ns / 1ps
// media_segment_frame_indexer: top level, configuration registers and the
// front / queue / back chain; depends on msfi_pkg, both interfaces and submodules
//
//  channel | direction | handshake         | carries
//  --------+-----------+-------------------+----------------------------------
//  seg     | in        | valid / ready     | opcode, stream, sequence, length,
//          |           |                   | packet, flags
//  frame   | out       | valid / ready     | gap, frame length/sequence/packet/
//          |           |                   | flags, four audio byte totals
//  cfg     | in        | cfg_we, no wait   | register index and data
//
// one segment transaction per cycle while the queue has room; a segment that
// closes a frame shows up on frame in the cycle after the back stage takes it
// from the queue; the back stage sets the rate, one queue entry per cycle while
// frame is not held off (one 32-bit add and one sequence compare); a two-entry
// queue keeps seg ready while the output waits; seg stalls only once frame holds off
// reset clears config, open frame state, audio totals, snapshots and the queue

module media_segment_frame_indexer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [msfi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [msfi_pkg::CFG_DATA_W-1:0]  cfg_data,
    msfi_seg_if.sink                         seg,
    msfi_frame_if.source                     frame
);
    import msfi_pkg::*;

    cfg_t    cfg_reg;
    logic    front_valid;
    logic    queue_ready;
    seg_op_t front_op;
    logic    back_valid;
    logic    back_ready;
    seg_op_t back_op;

    // configuration registers, writes to an unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VIDEO_STREAM:  cfg_reg.video_stream  <= cfg_data[STREAM_W-1:0];
                CFG_TRACK_COUNT:   cfg_reg.track_count   <= cfg_data[CNT_W-1:0];
                CFG_AUDIO_STREAMS: cfg_reg.audio_streams <= cfg_data[AUDIO_MAP_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // classify at the input: flush, video, matched audio track or ignored
    msfi_front u_front (
        .seg         (seg),
        .cfg         (cfg_reg),
        .queue_ready (queue_ready),
        .op_valid    (front_valid),
        .op          (front_op)
    );

    // decouples input acceptance from output backpressure
    msfi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (queue_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    // frame building, audio totals and the output register
    msfi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .op       (back_op),
        .frame    (frame)
    );

endmodule

// File: verif/media_segment_frame_indexer_test.sv
`timescale 1ns / 1ps
// media_segment_frame_indexer_test: self-checking bench for the frame indexer,
// with a scoreboard class that predicts frame entries and random-stall drivers
// depends on msfi_pkg, msfi_seg_if, msfi_frame_if and the block's rtl

module media_segment_frame_indexer_test;
    import msfi_pkg::*;

    localparam logic OP_SEGMENT   = 1'b0;
    localparam logic OP_FLUSH     = 1'b1;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   CYCLE_LIMIT  = 1000000;
    localparam int   PHASES       = 8;
    localparam int   PHASE_ITEMS  = 185;
    localparam int   MAX_GAP      = 8;
    localparam int   REPORT_MAX   = 10;

    // one segment transaction as seen on the seg channel
    typedef struct packed {
        logic                 opcode;
        logic [STREAM_W-1:0]  stream;
        logic [SEQ_W-1:0]     seq;
        logic [SEG_LEN_W-1:0] len;
        logic [PKT_W-1:0]     pkt;
        logic [FLAGS_W-1:0]   flags;
    } segment_t;

    // one frame index transaction as seen on the frame channel
    typedef struct packed {
        logic [GAP_W-1:0]                     gap;
        logic [BYTES_W-1:0]                   length;
        logic [SEQ_W-1:0]                     seq;
        logic [PKT_W-1:0]                     pkt;
        logic [FLAGS_W-1:0]                   flags;
        logic [TRACK_SLOTS-1:0][BYTES_W-1:0]  audio;
    } frame_entry_t;

    // predicts frame entries from accepted segments and checks the block's output
    class frame_index_scoreboard;
        logic [STREAM_W-1:0]                 video_stream  = '0;
        logic [CNT_W-1:0]                    track_count   = '0;
        logic [AUDIO_MAP_W-1:0]              audio_map     = '0;
        bit                                  frame_open    = 1'b0;
        logic [SEQ_W-1:0]                    open_seq      = '0;
        logic [BYTES_W-1:0]                  open_length   = '0;
        logic [PKT_W-1:0]                    open_pkt      = '0;
        logic [FLAGS_W-1:0]                  open_flags    = '0;
        logic [TRACK_SLOTS-1:0][BYTES_W-1:0] audio_totals  = '0;
        logic [TRACK_SLOTS-1:0][BYTES_W-1:0] audio_snapshot = '0;
        frame_entry_t                        frames_due[$];
        int unsigned                         failures      = 0;

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_VIDEO_STREAM:  video_stream = value[STREAM_W-1:0];
                CFG_TRACK_COUNT:   track_count  = value[CNT_W-1:0];
                CFG_AUDIO_STREAMS: audio_map    = value[AUDIO_MAP_W-1:0];
                default: ;
            endcase
        endfunction

        function frame_entry_t open_entry(logic [GAP_W-1:0] gap);
            frame_entry_t f;
            f.gap    = gap;
            f.length = open_length;
            f.seq    = open_seq;
            f.pkt    = open_pkt;
            f.flags  = open_flags;
            f.audio  = audio_snapshot;
            return f;
        endfunction

        // append a predicted frame entry at the tail
        function void queue_frame(frame_entry_t f);
            frames_due = {frames_due, f};
        endfunction

        function void note_segment(segment_t s);
            int unsigned n;
            bit          matched;
            n = (track_count > CNT_W'(AUDIO_TRACKS)) ? AUDIO_TRACKS : track_count;
            if (s.opcode == OP_FLUSH)
            begin
                // flush closes the open frame, totals stay
                if (frame_open)
                begin
                    queue_frame(open_entry('0));
                    frame_open = 1'b0;
                end
                return;
            end
            if (s.stream == video_stream)
            begin
                if (!frame_open)
                begin
                    // first frame after reset or flush: key flag, packet 0, no snapshot
                    frame_open     = 1'b1;
                    open_seq       = s.seq;
                    open_length    = BYTES_W'(s.len);
                    open_pkt       = '0;
                    open_flags     = KEY_FLAG;
                    audio_snapshot = '0;
                end
                else if (s.seq == open_seq)
                begin
                    open_length = open_length + BYTES_W'(s.len);
                end
                else
                begin
                    // gap counts missing sequence numbers mod 256
                    queue_frame(open_entry(GAP_W'(s.seq - open_seq - 8'd1)));
                    open_seq    = s.seq;
                    open_length = BYTES_W'(s.len);
                    open_pkt    = s.pkt;
                    open_flags  = s.flags;
                    for (int t = 0; t < TRACK_SLOTS; t++)
                        audio_snapshot[t] = (t < n) ? audio_totals[t] : '0;
                end
                return;
            end
            // lowest matching active track takes the bytes
            matched = 1'b0;
            for (int t = 0; t < TRACK_SLOTS; t++)
            begin
                if (!matched && t < n && audio_map[STREAM_W*t +: STREAM_W] == s.stream)
                begin
                    audio_totals[t] = audio_totals[t] + BYTES_W'(s.len);
                    matched = 1'b1;
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("frame mismatch on %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_frame(frame_entry_t got);
            frame_entry_t want;
            if (frames_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected frame transaction: seq %0h length %0h",
                             got.seq, got.length);
                return;
            end
            want = frames_due.pop_front();
            compare_field("gap_frames", 32'(want.gap), 32'(got.gap));
            compare_field("frame_length", want.length, got.length);
            compare_field("frame_sequence", 32'(want.seq), 32'(got.seq));
            compare_field("frame_packet", want.pkt, got.pkt);
            compare_field("frame_flags", 32'(want.flags), 32'(got.flags));
            for (int t = 0; t < TRACK_SLOTS; t++)
                compare_field($sformatf("audio_bytes_track%0d", t), want.audio[t],
                              got.audio[t]);
        endfunction

        function int unsigned pending();
            return frames_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic rx_ready = 1'b0;

    // idle percentages for the current phase, sender side and receiver side
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;

    // generator's view of the configuration and the sequence it is building
    logic [STREAM_W-1:0]    cur_video = '0;
    logic [AUDIO_MAP_W-1:0] cur_map = '0;
    logic [SEQ_W-1:0]       gen_seq = '0;

    int unsigned cycles = 0;

    frame_index_scoreboard sb = new();

    msfi_seg_if   seg_ch ();
    msfi_frame_if frame_ch ();

    assign frame_ch.ready = rx_ready;

    media_segment_frame_indexer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seg       (seg_ch),
        .frame     (frame_ch)
    );

    always #5 clk = ~clk;

    // run limit, far above the slowest correct run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // frame side: check each accepted transaction, then pick ready for the next edge
    always @(posedge clk)
    begin : frame_side
        frame_entry_t got;
        if (rst_n && frame_ch.valid && rx_ready)
        begin
            got.gap      = frame_ch.gap_frames;
            got.length   = frame_ch.frame_length;
            got.seq      = frame_ch.frame_sequence;
            got.pkt      = frame_ch.frame_packet;
            got.flags    = frame_ch.frame_flags;
            got.audio[0] = frame_ch.audio_bytes_track0;
            got.audio[1] = frame_ch.audio_bytes_track1;
            got.audio[2] = frame_ch.audio_bytes_track2;
            got.audio[3] = frame_ch.audio_bytes_track3;
            sb.check_frame(got);
        end
        rx_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic segment_t seg_of(logic op, logic [STREAM_W-1:0] stream,
                                        logic [SEQ_W-1:0] seq, logic [SEG_LEN_W-1:0] len,
                                        logic [PKT_W-1:0] pkt, logic [FLAGS_W-1:0] flags);
        segment_t s;
        s.opcode = op;
        s.stream = stream;
        s.seq    = seq;
        s.len    = len;
        s.pkt    = pkt;
        s.flags  = flags;
        return s;
    endfunction

    // mostly well-formed video runs with audio mixed in, some noise and flushes
    function automatic segment_t random_segment(output bit counted);
        segment_t    s;
        int unsigned pick;
        int unsigned roll;
        int unsigned track;
        pick     = $urandom_range(99);
        roll     = $urandom_range(9);
        s.opcode = OP_SEGMENT;
        s.stream = STREAM_W'($urandom_range(127));
        s.seq    = SEQ_W'($urandom_range(255));
        s.len    = (roll == 0) ? '0 : (roll == 1) ? '1 : SEG_LEN_W'($urandom_range(65535));
        s.pkt    = $urandom();
        s.flags  = FLAGS_W'($urandom_range(255));
        counted  = 1'b1;
        if (pick < 55)
        begin
            // video: stay on the open sequence, step by one, or jump
            s.stream = cur_video;
            roll = $urandom_range(99);
            if (roll < 55)
                s.seq = gen_seq;
            else if (roll < 85)
                s.seq = gen_seq + 8'd1;
            gen_seq = s.seq;
        end
        else if (pick < 87)
        begin
            track    = $urandom_range(TRACK_SLOTS - 1);
            s.stream = cur_map[STREAM_W*track +: STREAM_W];
        end
        else if (pick < 95)
        begin
            // random stream, usually unmapped
            counted = 1'b0;
        end
        else
        begin
            s.opcode = OP_FLUSH;
        end
        return s;
    endfunction

    // sender gap drawn per cycle from the idle percentage
    task automatic send(segment_t s);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_ch.valid            <= 1'b1;
        seg_ch.opcode           <= s.opcode;
        seg_ch.stream_number    <= s.stream;
        seg_ch.segment_sequence <= s.seq;
        seg_ch.segment_length   <= s.len;
        seg_ch.packet_number    <= s.pkt;
        seg_ch.segment_flags    <= s.flags;
        @(posedge clk);
        while (!seg_ch.ready)
            @(posedge clk);
        sb.note_segment(s);
    endtask

    // drop valid, let all frames arrive, then let non-result work settle
    task automatic wait_idle();
        seg_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic configure(logic [STREAM_W-1:0] video, logic [CNT_W-1:0] count,
                             logic [AUDIO_MAP_W-1:0] map);
        write_reg(CFG_VIDEO_STREAM, CFG_DATA_W'(video));
        write_reg(CFG_TRACK_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_AUDIO_STREAMS, map);
        cfg_we    <= 1'b0;
        cur_video = video;
        cur_map   = map;
    endtask

    function automatic logic [AUDIO_MAP_W-1:0] random_map(logic [STREAM_W-1:0] video);
        logic [AUDIO_MAP_W-1:0] map;
        int unsigned            roll;
        map = AUDIO_MAP_W'($urandom());
        for (int t = 0; t < TRACK_SLOTS; t++)
        begin
            // now and then alias the video stream or the track below
            roll = $urandom_range(7);
            if (roll == 0)
                map[STREAM_W*t +: STREAM_W] = video;
            else if (roll == 1 && t > 0)
                map[STREAM_W*t +: STREAM_W] = map[STREAM_W*(t-1) +: STREAM_W];
        end
        return map;
    endfunction

    initial
    begin : stimulus
        segment_t        s;
        bit              counted;
        int unsigned     sent;
        logic [STREAM_W-1:0] video;

        seg_ch.valid            = 1'b0;
        seg_ch.opcode           = OP_SEGMENT;
        seg_ch.stream_number    = '0;
        seg_ch.segment_sequence = '0;
        seg_ch.segment_length   = '0;
        seg_ch.packet_number    = '0;
        seg_ch.segment_flags    = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: track 2 aliases track 0, track 3 aliases the video stream
        configure(7'd5, 3'd4, {7'd5, 7'd10, 7'd20, 7'd10});
        send(seg_of(OP_FLUSH, 7'd0, 8'd0, 16'd0, 32'd0, 8'd0));          // nothing open
        send(seg_of(OP_SEGMENT, 7'd10, 8'd3, 16'd100, 32'd7, 8'd1));      // lowest track wins
        send(seg_of(OP_SEGMENT, 7'd20, 8'd3, 16'hffff, 32'd8, 8'd2));
        send(seg_of(OP_SEGMENT, 7'd5, 8'hff, 16'd0, 32'hffffffff, 8'hff)); // first frame
        send(seg_of(OP_SEGMENT, 7'd5, 8'hff, 16'hffff, 32'd9, 8'h00));   // same frame
        send(seg_of(OP_SEGMENT, 7'd127, 8'd1, 16'd55, 32'd10, 8'h0f));   // unmapped
        send(seg_of(OP_SEGMENT, 7'd0, 8'd1, 16'd66, 32'd11, 8'hf0));     // unmapped
        send(seg_of(OP_SEGMENT, 7'd5, 8'd0, 16'd12, 32'h12345678, 8'h00)); // seq wraps
        send(seg_of(OP_SEGMENT, 7'd10, 8'd0, 16'd1, 32'd12, 8'd0));
        send(seg_of(OP_SEGMENT, 7'd5, 8'd2, 16'd13, 32'h80000000, 8'h80)); // gap of one
        send(seg_of(OP_SEGMENT, 7'd5, 8'd1, 16'd14, 32'd14, 8'h10));     // backwards
        send(seg_of(OP_SEGMENT, 7'd5, 8'd1, 16'd15, 32'd15, 8'h01));
        send(seg_of(OP_SEGMENT, 7'd5, 8'd0, 16'd16, 32'd16, 8'h7f));
        send(seg_of(OP_FLUSH, 7'd127, 8'hff, 16'hffff, 32'hffffffff, 8'hff));
        send(seg_of(OP_FLUSH, 7'd5, 8'd1, 16'd1, 32'd1, 8'd1));          // already closed
        send(seg_of(OP_SEGMENT, 7'd5, 8'd7, 16'd17, 32'd17, 8'h00));     // first again
        send(seg_of(OP_SEGMENT, 7'd20, 8'd7, 16'd18, 32'd18, 8'h00));
        send(seg_of(OP_SEGMENT, 7'd5, 8'd8, 16'd19, 32'd19, 8'h55));
        send(seg_of(OP_SEGMENT, 7'd5, 8'd8, 16'd20, 32'd20, 8'haa));
        send(seg_of(OP_FLUSH, 7'd0, 8'd0, 16'd0, 32'd0, 8'd0));
        wait_idle();

        // random phases, each with its own setting and idle pattern
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 47;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 47;
                end
                default:
                begin
                    tx_idle_pct  = 13;
                    rx_stall_pct = 13;
                end
            endcase
            case (phase)
                0: configure(7'd5, 3'd4, {7'd40, 7'd30, 7'd20, 7'd10});
                1: configure(7'd127, 3'd7, 28'hfffffff);          // every track is video
                2: configure(7'd0, 3'd7, {7'd4, 7'd3, 7'd127, 7'd1}); // count clamps
                3: configure(7'd0, 3'd0, 28'h0);                  // no tracks kept
                4: configure(7'd64, 3'd2, {7'd9, 7'd9, 7'd33, 7'd33}); // upper tracks zero
                default:
                begin
                    video = STREAM_W'($urandom_range(127));
                    configure(video, CNT_W'($urandom_range(7)), random_map(video));
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                s = random_segment(counted);
                send(s);
                if (counted)
                    sent++;
            end
            wait_idle();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
